>>> hw/rtl/mbtcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcp_pkg
// Shared widths, codes and types for the Modbus TCP client framer.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   localparam int MAX_ADU     = 260;
   localparam int MAX_MBAP_LEN = MAX_ADU - 6;
   localparam int FRAME_BYTES = 12;

   localparam logic [2:0] ACT_READ    = 3'd0;
   localparam logic [2:0] ACT_WRITE   = 3'd1;
   localparam logic [2:0] ACT_RX_BYTE = 3'd2;
   localparam logic [2:0] ACT_TIMEOUT = 3'd3;
   localparam logic [2:0] ACT_LINK    = 3'd4;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_COUNT = 4'd1;
   localparam logic [3:0] ST_BAD_HDR   = 4'd2;
   localparam logic [3:0] ST_BAD_EXC   = 4'd3;
   localparam logic [3:0] ST_EXCEPTION = 4'd4;
   localparam logic [3:0] ST_WRONG_FN  = 4'd5;
   localparam logic [3:0] ST_RD_FORMAT = 4'd6;
   localparam logic [3:0] ST_ECHO      = 4'd7;
   localparam logic [3:0] ST_TIMEOUT   = 4'd8;
   localparam logic [3:0] ST_LINK      = 4'd9;

   localparam logic [7:0] FN_READ  = 8'h03;
   localparam logic [7:0] FN_WRITE = 8'h06;
   localparam logic [7:0] FN_EXC   = 8'h80;

   localparam logic [15:0] MAX_COUNT    = 16'd125;
   localparam logic [7:0]  PROTO_ID     = 8'h00;
   localparam logic [7:0]  REQ_LEN      = 8'd6;
   localparam logic [7:0]  WR_PDU_LEN   = 8'd5;

   typedef enum logic [1:0] {
      KIND_TX,
      KIND_VALUE,
      KIND_STATUS
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] data;
      logic [3:0]  status;
      logic [7:0]  exc;
   } res_type;

endpackage

>>> hw/rtl/modbus_tcp_master_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_master_framer
// Modbus TCP client: frames read holding register and write single register
// requests and checks response bytes one at a time.
// ----------------------------------------------------------------------------
// Each accepted item is processed in its transfer cycle and its results land
// in one result register that drains one result per cycle while rsp_tready
// is high. Items that give at most one result each let response bytes stream
// at one per cycle while rsp_tready stays high; a request gives twelve transmit
// bytes, which leave through the result register, and a response byte that
// gives a register value and the ending status gives two results. The next
// item is taken in the cycle the last pending result transfers.
module modbus_tcp_master_framer (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: reg_addr[15:0], operand[31:16], rx_byte[39:32]
   input  logic [mbtcp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: action[2:0]
   input  logic [mbtcp_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: data[15:0], status[19:16], exception_code[27:20], zero[31:28]
   output logic [mbtcp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic [mbtcp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [7:0]                        csr_wr_data
);
   import mbtcp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PDU
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  unit_id_ff, unit_id_in;
   logic [15:0] txn_id_ff, txn_id_in;
   logic [7:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  pdu_len_ff, pdu_len_in;
   logic        is_write_ff, is_write_in;
   logic [15:0] saved_addr_ff, saved_addr_in;
   logic [15:0] saved_opd_ff, saved_opd_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [3:0]  pend_err_ff, pend_err_in;
   logic [7:0]  saved_exc_ff, saved_exc_in;

   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  idx_ff, idx_in;
   logic        tx_ff, tx_in;
   res_type     res_ff [2];
   res_type     res_in [2];

   logic        req_fire, rsp_fire, drain_last;
   logic [2:0]  action;
   logic [15:0] reg_addr, operand;
   logic [7:0]  rx_byte;
   res_type     out_res;
   logic [7:0]  frame_byte;

   assign action   = req_tuser[2:0];
   assign reg_addr = req_tdata[15:0];
   assign operand  = req_tdata[31:16];
   assign rx_byte  = req_tdata[39:32];

   assign rsp_tvalid = (cnt_ff != 4'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign drain_last = rsp_fire && (idx_ff + 4'd1 == cnt_ff);
   assign req_tready = (cnt_ff == 4'd0) || drain_last;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      logic        emit_val, emit_stat, tx_req, bad;
      logic [3:0]  stat, err;
      logic [7:0]  fn, want;
      logic [15:0] len;
      logic [17:0] rd_len;
      res_type     val_res, stat_res;

      phase_in      = phase_ff;
      unit_id_in    = csr_wr_en ? csr_wr_data : unit_id_ff;
      txn_id_in     = txn_id_ff;
      byte_pos_in   = byte_pos_ff;
      pdu_len_in    = pdu_len_ff;
      is_write_in   = is_write_ff;
      saved_addr_in = saved_addr_ff;
      saved_opd_in  = saved_opd_ff;
      high_byte_in  = high_byte_ff;
      pend_err_in   = pend_err_ff;
      saved_exc_in  = saved_exc_ff;

      emit_val  = 1'b0;
      emit_stat = 1'b0;
      tx_req    = 1'b0;
      bad       = 1'b0;
      stat      = ST_OK;
      err       = pend_err_ff;
      fn        = is_write_ff ? FN_WRITE : FN_READ;
      want      = 8'h00;
      len       = {high_byte_ff, rx_byte};
      rd_len    = {1'b0, saved_opd_ff, 1'b0} + 18'd2;
      val_res   = '{kind: KIND_VALUE, data: {high_byte_ff, rx_byte}, status: ST_OK,
                    exc: 8'h00};

      if (req_fire) begin
         case (action)
            ACT_READ, ACT_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  if (action == ACT_READ && (operand == 16'd0 || operand > MAX_COUNT)) begin
                     emit_stat = 1'b1;
                     stat      = ST_BAD_COUNT;
                  end else begin
                     txn_id_in     = (txn_id_ff == 16'hFFFF) ? 16'd1 : txn_id_ff + 16'd1;
                     is_write_in   = (action == ACT_WRITE);
                     saved_addr_in = reg_addr;
                     saved_opd_in  = operand;
                     pend_err_in   = ST_OK;
                     saved_exc_in  = 8'h00;
                     high_byte_in  = 8'h00;
                     pdu_len_in    = 8'd0;
                     byte_pos_in   = 8'd0;
                     phase_in      = PH_HEADER;
                     tx_req        = 1'b1;
                  end
               end
            end
            ACT_RX_BYTE: begin
               if (phase_ff == PH_HEADER) begin
                  case (byte_pos_ff)
                     8'd0: bad = (rx_byte != txn_id_ff[15:8]);
                     8'd1: bad = (rx_byte != txn_id_ff[7:0]);
                     8'd2, 8'd3: bad = (rx_byte != PROTO_ID);
                     8'd4: high_byte_in = rx_byte;
                     8'd5: begin
                        if (len < 16'd2 || len > 16'(MAX_MBAP_LEN)) begin
                           bad = 1'b1;
                        end else begin
                           pdu_len_in = rx_byte - 8'd1;
                        end
                     end
                     default: bad = (rx_byte != unit_id_ff);
                  endcase
                  err         = bad ? ST_BAD_HDR : pend_err_ff;
                  pend_err_in = err;
                  if (byte_pos_ff < 8'd6) begin
                     byte_pos_in = byte_pos_ff + 8'd1;
                  end else if (err != ST_OK) begin
                     phase_in  = PH_IDLE;
                     emit_stat = 1'b1;
                     stat      = err;
                  end else begin
                     phase_in    = PH_PDU;
                     byte_pos_in = 8'd0;
                  end
               end else if (phase_ff == PH_PDU) begin
                  if (byte_pos_ff == 8'd0) begin
                     if (rx_byte == (fn | FN_EXC)) begin
                        err = (pdu_len_ff < 8'd2) ? ST_BAD_EXC : ST_EXCEPTION;
                     end else if (rx_byte != fn) begin
                        err = ST_WRONG_FN;
                     end else if (!is_write_ff && rd_len != {10'd0, pdu_len_ff}) begin
                        err = ST_RD_FORMAT;
                     end else if (is_write_ff && pdu_len_ff != WR_PDU_LEN) begin
                        err = ST_ECHO;
                     end
                  end else if (pend_err_ff == ST_EXCEPTION) begin
                     if (byte_pos_ff == 8'd1) begin
                        saved_exc_in = rx_byte;
                     end
                  end else if (pend_err_ff == ST_OK) begin
                     if (is_write_ff) begin
                        case (byte_pos_ff)
                           8'd1:    want = saved_addr_ff[15:8];
                           8'd2:    want = saved_addr_ff[7:0];
                           8'd3:    want = saved_opd_ff[15:8];
                           default: want = saved_opd_ff[7:0];
                        endcase
                        if (rx_byte != want) begin
                           err = ST_ECHO;
                        end
                     end else if (byte_pos_ff == 8'd1) begin
                        if (rx_byte != {saved_opd_ff[6:0], 1'b0}) begin
                           err = ST_RD_FORMAT;
                        end
                     end else if (!byte_pos_ff[0]) begin
                        high_byte_in = rx_byte;
                     end else begin
                        emit_val = 1'b1;
                     end
                  end
                  pend_err_in = err;
                  if ({1'b0, byte_pos_ff} + 9'd1 >= {1'b0, pdu_len_ff}) begin
                     phase_in  = PH_IDLE;
                     emit_stat = 1'b1;
                     stat      = err;
                  end else begin
                     byte_pos_in = byte_pos_ff + 8'd1;
                  end
               end
            end
            ACT_TIMEOUT, ACT_LINK: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in  = PH_IDLE;
                  emit_stat = 1'b1;
                  stat      = (action == ACT_TIMEOUT) ? ST_TIMEOUT : ST_LINK;
               end
            end
            default: ;
         endcase
      end

      stat_res = '{kind: KIND_STATUS, data: 16'h0000, status: stat,
                   exc: (stat == ST_EXCEPTION) ? saved_exc_in : 8'h00};

      // advance or drop the pending results
      tx_in     = tx_ff;
      res_in[0] = res_ff[0];
      res_in[1] = res_ff[1];
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      if (drain_last) begin
         cnt_in = 4'd0;
         idx_in = 4'd0;
      end else if (rsp_fire) begin
         idx_in = idx_ff + 4'd1;
      end

      if (req_fire) begin
         idx_in    = 4'd0;
         tx_in     = tx_req;
         res_in[0] = emit_val ? val_res : stat_res;
         res_in[1] = stat_res;
         if (tx_req) begin
            cnt_in = 4'(FRAME_BYTES);
         end else begin
            cnt_in = {3'd0, emit_val} + {3'd0, emit_stat};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         unit_id_ff    <= 8'h00;
         txn_id_ff     <= 16'h0000;
         byte_pos_ff   <= 8'd0;
         pdu_len_ff    <= 8'd0;
         is_write_ff   <= 1'b0;
         saved_addr_ff <= 16'h0000;
         saved_opd_ff  <= 16'h0000;
         high_byte_ff  <= 8'h00;
         pend_err_ff   <= ST_OK;
         saved_exc_ff  <= 8'h00;
         cnt_ff        <= 4'd0;
         idx_ff        <= 4'd0;
         tx_ff         <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         unit_id_ff    <= unit_id_in;
         txn_id_ff     <= txn_id_in;
         byte_pos_ff   <= byte_pos_in;
         pdu_len_ff    <= pdu_len_in;
         is_write_ff   <= is_write_in;
         saved_addr_ff <= saved_addr_in;
         saved_opd_ff  <= saved_opd_in;
         high_byte_ff  <= high_byte_in;
         pend_err_ff   <= pend_err_in;
         saved_exc_ff  <= saved_exc_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         tx_ff         <= tx_in;
      end
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
   end

   always_comb begin
      case (idx_ff)
         4'd0:    frame_byte = txn_id_ff[15:8];
         4'd1:    frame_byte = txn_id_ff[7:0];
         4'd5:    frame_byte = REQ_LEN;
         4'd6:    frame_byte = unit_id_ff;
         4'd7:    frame_byte = is_write_ff ? FN_WRITE : FN_READ;
         4'd8:    frame_byte = saved_addr_ff[15:8];
         4'd9:    frame_byte = saved_addr_ff[7:0];
         4'd10:   frame_byte = saved_opd_ff[15:8];
         4'd11:   frame_byte = saved_opd_ff[7:0];
         default: frame_byte = PROTO_ID;
      endcase
      if (tx_ff) begin
         out_res = '{kind: KIND_TX, data: {8'h00, frame_byte}, status: ST_OK,
                     exc: 8'h00};
      end else begin
         out_res = res_ff[idx_ff[0]];
      end
   end

   assign rsp_tdata = {4'h0, out_res.exc, out_res.status, out_res.data};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = (idx_ff + 4'd1 == cnt_ff);

`ifndef NO_ASSERTIONS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff < cnt_ff && cnt_ff <= 4'(FRAME_BYTES)))
      else $error("result index outside pending results");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_STATUS) |-> rsp_tlast)
      else $error("status result not marked last");

   a_txn_nonzero: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_IDLE && tx_in) |=> (txn_id_ff != 16'h0000))
      else $error("transaction id zero after request");

   a_no_accept_busy_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("item taken while results stall");
`endif

endmodule

>>> verif/tb_modbus_tcp_master_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_tcp_master_framer
// Self-checking bench for the Modbus TCP client framer. It drives requests,
// response bytes, timeouts and link errors through the request stream and
// predicts every transmit byte, register value and status with its own model
// of the client. Each result transfer is compared field by field against the
// oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_modbus_tcp_master_framer;
   import mbtcp_pkg::*;

   localparam int CYCLE_LIMIT = 500_000;
   localparam int MAX_PRINTS  = 40;

   typedef enum logic [1:0] {
      CL_IDLE,
      CL_HEADER,
      CL_PDU
   } client_phase_type;

   typedef enum int {
      RP_GOOD,
      RP_EXCEPTION,
      RP_EXC_SHORT,
      RP_FLIP,
      RP_LENGTH
   } reply_kind_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] data;
      logic [3:0]  status;
      logic [7:0]  exc;
      logic        last;
   } client_result_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_wr_en;
   logic [7:0]             csr_wr_data;

   // client model state
   logic [7:0]       cl_unit    = 8'h00;
   logic [15:0]      cl_txn     = 16'h0000;
   client_phase_type cl_phase   = CL_IDLE;
   logic [7:0]       cl_pos     = 8'h00;
   logic [7:0]       cl_pdu_len = 8'h00;
   logic             cl_wr      = 1'b0;
   logic [15:0]      cl_addr    = 16'h0000;
   logic [15:0]      cl_opd     = 16'h0000;
   logic [7:0]       cl_hi      = 8'h00;
   logic [3:0]       cl_err     = ST_OK;
   logic [7:0]       cl_exc     = 8'h00;

   client_result_type client_outputs[$];
   logic [7:0]        reply_bytes[$];

   int cycle_count = 0;
   int err_count   = 0;
   int hold_cycles = 0;
   int rx_stall    = 0;
   bit rsp_beat    = 1'b0;
   bit tx_idle     = 1'b1;
   bit rx_idle     = 1'b1;

   modbus_tcp_master_framer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void push_result(input kind_type k, input logic [15:0] d,
                                       input logic [3:0] s, input logic [7:0] e);
      client_result_type r;
      r.kind   = k;
      r.data   = d;
      r.status = s;
      r.exc    = e;
      r.last   = 1'b0;
      client_outputs.push_back(r);
   endfunction

   function automatic void close_txn(input logic [3:0] s);
      cl_phase = CL_IDLE;
      push_result(KIND_STATUS, 16'h0000, s, (s == ST_EXCEPTION) ? cl_exc : 8'h00);
   endfunction

   function automatic void client_step(input logic [2:0] act, input logic [15:0] addr,
                                       input logic [15:0] opd, input logic [7:0] rx);
      int          n0;
      logic        bad;
      logic [15:0] len;
      logic [15:0] twice;
      logic [7:0]  fn;
      logic [7:0]  want;
      logic [95:0] frame;
      n0 = client_outputs.size();
      case (act)
         ACT_READ, ACT_WRITE: begin
            if (cl_phase == CL_IDLE) begin
               if (act == ACT_READ && (opd == 16'h0000 || opd > MAX_COUNT)) begin
                  push_result(KIND_STATUS, 16'h0000, ST_BAD_COUNT, 8'h00);
               end else begin
                  cl_txn = cl_txn + 16'd1;
                  if (cl_txn == 16'h0000) cl_txn = 16'd1;
                  cl_wr      = (act == ACT_WRITE);
                  cl_addr    = addr;
                  cl_opd     = opd;
                  cl_err     = ST_OK;
                  cl_exc     = 8'h00;
                  cl_hi      = 8'h00;
                  cl_pdu_len = 8'h00;
                  cl_pos     = 8'h00;
                  cl_phase   = CL_HEADER;
                  fn = cl_wr ? FN_WRITE : FN_READ;
                  frame = {cl_txn, PROTO_ID, PROTO_ID, 8'h00, REQ_LEN, cl_unit, fn, addr, opd};
                  for (int i = 0; i < FRAME_BYTES; i++)
                     push_result(KIND_TX, {8'h00, frame[95-8*i -: 8]}, ST_OK, 8'h00);
               end
            end
         end
         ACT_RX_BYTE: begin
            if (cl_phase == CL_HEADER) begin
               bad = 1'b0;
               case (cl_pos)
                  8'd0: bad = (rx != cl_txn[15:8]);
                  8'd1: bad = (rx != cl_txn[7:0]);
                  8'd2, 8'd3: bad = (rx != PROTO_ID);
                  8'd4: cl_hi = rx;
                  8'd5: begin
                     len = {cl_hi, rx};
                     if (len < 2 || len > MAX_MBAP_LEN) bad = 1'b1;
                     else cl_pdu_len = 8'(len - 16'd1);
                  end
                  default: bad = (rx != cl_unit);
               endcase
               if (bad) cl_err = ST_BAD_HDR;
               if (cl_pos < 8'd6) begin
                  cl_pos = cl_pos + 8'd1;
               end else if (cl_err != ST_OK) begin
                  close_txn(cl_err);
               end else begin
                  cl_phase = CL_PDU;
                  cl_pos   = 8'h00;
               end
            end else if (cl_phase == CL_PDU) begin
               fn    = cl_wr ? FN_WRITE : FN_READ;
               twice = cl_opd << 1;
               if (cl_pos == 8'd0) begin
                  if (rx == (fn | FN_EXC))
                     cl_err = (cl_pdu_len < 8'd2) ? ST_BAD_EXC : ST_EXCEPTION;
                  else if (rx != fn)
                     cl_err = ST_WRONG_FN;
                  else if (!cl_wr && 32'(cl_pdu_len) != 2 + 2 * 32'(cl_opd))
                     cl_err = ST_RD_FORMAT;
                  else if (cl_wr && cl_pdu_len != WR_PDU_LEN)
                     cl_err = ST_ECHO;
               end else if (cl_err == ST_EXCEPTION) begin
                  if (cl_pos == 8'd1) cl_exc = rx;
               end else if (cl_err == ST_OK) begin
                  if (cl_wr) begin
                     case (cl_pos)
                        8'd1:    want = cl_addr[15:8];
                        8'd2:    want = cl_addr[7:0];
                        8'd3:    want = cl_opd[15:8];
                        default: want = cl_opd[7:0];
                     endcase
                     if (rx != want) cl_err = ST_ECHO;
                  end else if (cl_pos == 8'd1) begin
                     if (rx != twice[7:0]) cl_err = ST_RD_FORMAT;
                  end else if (!cl_pos[0]) begin
                     cl_hi = rx;
                  end else begin
                     push_result(KIND_VALUE, {cl_hi, rx}, ST_OK, 8'h00);
                  end
               end
               if (32'(cl_pos) + 1 >= 32'(cl_pdu_len)) close_txn(cl_err);
               else cl_pos = cl_pos + 8'd1;
            end
         end
         ACT_TIMEOUT, ACT_LINK: begin
            if (cl_phase != CL_IDLE) close_txn((act == ACT_TIMEOUT) ? ST_TIMEOUT : ST_LINK);
         end
         default: ;
      endcase
      if (client_outputs.size() > n0) client_outputs[client_outputs.size()-1].last = 1'b1;
   endfunction

   // build the slave reply for the open transaction
   function automatic void build_reply(input reply_kind_type how, input logic [7:0] code);
      logic [7:0]  pdu[$];
      logic [7:0]  fn;
      logic [15:0] len;
      logic [15:0] twice;
      logic [55:0] hdr;
      int          pos;
      fn    = cl_wr ? FN_WRITE : FN_READ;
      twice = cl_opd << 1;
      reply_bytes.delete();
      if (how == RP_EXCEPTION) begin
         pdu.push_back(fn | FN_EXC);
         pdu.push_back(code);
      end else if (how == RP_EXC_SHORT) begin
         pdu.push_back(fn | FN_EXC);
      end else if (cl_wr) begin
         pdu.push_back(fn);
         pdu.push_back(cl_addr[15:8]);
         pdu.push_back(cl_addr[7:0]);
         pdu.push_back(cl_opd[15:8]);
         pdu.push_back(cl_opd[7:0]);
      end else begin
         pdu.push_back(fn);
         pdu.push_back(twice[7:0]);
         for (int i = 0; i < 2 * int'(cl_opd); i++) pdu.push_back(8'($urandom));
      end
      len = 16'(pdu.size() + 1);
      if (how == RP_LENGTH) begin
         case ($urandom_range(0, 6))
            0:       len = 16'd0;
            1:       len = 16'd1;
            2:       len = 16'd2;
            3:       len = 16'(MAX_MBAP_LEN);
            4:       len = 16'(MAX_MBAP_LEN + 1);
            5:       len = 16'($urandom);
            default: len = 16'($urandom_range(2, 24));
         endcase
         if (len >= 2 && len <= MAX_MBAP_LEN) begin
            while (pdu.size() > int'(len) - 1) pdu.pop_back();
            while (pdu.size() < int'(len) - 1) pdu.push_back(8'($urandom));
         end
      end
      hdr = {cl_txn, PROTO_ID, PROTO_ID, len, cl_unit};
      for (int i = 0; i < 7; i++) reply_bytes.push_back(hdr[55-8*i -: 8]);
      foreach (pdu[j]) reply_bytes.push_back(pdu[j]);
      if (how == RP_FLIP) begin
         pos = $urandom_range(0, (reply_bytes.size() > 11) ? 10 : reply_bytes.size() - 1);
         reply_bytes[pos] = reply_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
   endfunction

   // -------------------------------------------------------------- drivers

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   task automatic send_item(input logic [2:0] act, input logic [15:0] addr,
                            input logic [15:0] opd, input logic [7:0] rx);
      int gap;
      gap = tx_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {rx, opd, addr};
      req_tuser  <= act;
      req_tvalid <= 1'b1;
      @(negedge clock);
      while (req_tready !== 1'b1) @(negedge clock);
      @(posedge clock);
      client_step(act, addr, opd, rx);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (client_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit(input logic [7:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cl_unit = value;
   endtask

   // stream reply bytes until the transaction closes; cut short on request
   task automatic play_reply(input int cut, inout int used);
      for (int i = 0; i < cut && cl_phase != CL_IDLE; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_item(3'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 8'($urandom));
         send_item(ACT_RX_BYTE, 16'($urandom), 16'($urandom), reply_bytes[i]);
         used++;
      end
      if (cl_phase != CL_IDLE) begin
         send_item($urandom_range(0, 1) ? ACT_TIMEOUT : ACT_LINK,
                   16'($urandom), 16'($urandom), 8'($urandom));
         used++;
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_noise();
      write_unit(8'h5A);
      send_item(ACT_RX_BYTE, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_item(ACT_TIMEOUT, 16'h0000, 16'h0000, 8'h00);
      send_item(ACT_LINK, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_item(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_item(3'd6, 16'h0000, 16'h0000, 8'h00);
      send_item(3'd7, 16'hA5A5, 16'h5A5A, 8'hC3);
   endtask

   task automatic test_count_limits();
      send_item(ACT_READ, 16'h1234, 16'd0, 8'h00);
      send_item(ACT_READ, 16'hFFFF, MAX_COUNT + 16'd1, 8'hFF);
      send_item(ACT_READ, 16'h0000, 16'hFFFF, 8'h00);
   endtask

   task automatic test_busy_drop();
      send_item(ACT_READ, 16'hFFFF, MAX_COUNT, 8'h00);
      send_item(ACT_WRITE, 16'h0101, 16'h0202, 8'h00);
      send_item(ACT_LINK, 16'h0000, 16'h0000, 8'h00);
      send_item(ACT_WRITE, 16'h0000, 16'hFFFF, 8'h00);
      send_item(ACT_TIMEOUT, 16'h0000, 16'h0000, 8'h00);
   endtask

   task automatic test_exception_zero();
      int used;
      used = 0;
      send_item(ACT_READ, 16'h8001, 16'd1, 8'h00);
      build_reply(RP_EXCEPTION, 8'h00);
      play_reply(reply_bytes.size(), used);
   endtask

   task automatic test_backpressure();
      int used;
      used = 0;
      wait_drained();
      tx_idle = 1'b0;
      hold_cycles = 300;
      send_item(ACT_READ, 16'($urandom), 16'd3, 8'h00);
      build_reply(RP_GOOD, 8'h00);
      play_reply(reply_bytes.size(), used);
      send_item(ACT_WRITE, 16'($urandom), 16'($urandom), 8'h00);
      build_reply(RP_GOOD, 8'h00);
      play_reply(reply_bytes.size(), used);
      wait_drained();
      tx_idle = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [7:0] unit, input bit idle, input int budget);
      int             used;
      int             pick;
      int             cut;
      logic           wr;
      logic [15:0]    opd;
      logic [7:0]     code;
      reply_kind_type how;
      write_unit(unit);
      tx_idle = idle;
      rx_idle = idle;
      used = 0;
      while (used < budget) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            send_item(3'($urandom_range(2, 7)), 16'($urandom), 16'($urandom), 8'($urandom));
         end else if (pick == 1) begin
            opd = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(126, 65535));
            send_item(ACT_READ, 16'($urandom), opd, 8'($urandom));
            used++;
         end else begin
            wr = 1'($urandom_range(0, 1));
            if (wr) opd = 16'($urandom);
            else if ($urandom_range(0, 11) == 0) opd = 16'($urandom_range(1, 125));
            else opd = 16'($urandom_range(1, 4));
            send_item(wr ? ACT_WRITE : ACT_READ, 16'($urandom), opd, 8'($urandom));
            used++;
            pick = $urandom_range(0, 99);
            if (pick < 50) how = RP_GOOD;
            else if (pick < 62) how = RP_EXCEPTION;
            else if (pick < 68) how = RP_EXC_SHORT;
            else if (pick < 88) how = RP_FLIP;
            else how = RP_LENGTH;
            code = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            build_reply(how, code);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, reply_bytes.size() - 1)
                                              : reply_bytes.size();
            play_reply(cut, used);
         end
      end
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // ------------------------------------------------------- result side

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_beat) rx_stall = rx_idle ? $urandom_range(0, 11) : 0;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin : check_results
      client_result_type head;
      rsp_beat = 1'b0;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         rsp_beat = 1'b1;
         if (client_outputs.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata, 0);
         end else begin
            head = client_outputs.pop_front();
            if (rsp_tuser !== head.kind) report_mismatch("kind", rsp_tuser, head.kind);
            if (rsp_tdata[15:0] !== head.data) report_mismatch("data", rsp_tdata[15:0], head.data);
            if (rsp_tdata[19:16] !== head.status)
               report_mismatch("status", rsp_tdata[19:16], head.status);
            if (rsp_tdata[27:20] !== head.exc)
               report_mismatch("exception code", rsp_tdata[27:20], head.exc);
            if (rsp_tdata[31:28] !== 4'h0) report_mismatch("pad bits", rsp_tdata[31:28], 0);
            if (rsp_tlast !== head.last) report_mismatch("last", rsp_tlast, head.last);
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_idle_noise();
      test_count_limits();
      test_busy_drop();
      test_exception_zero();
      test_backpressure();
      test_random_traffic(8'hFF, 1'b1, 15);
      test_random_traffic(8'h00, 1'b0, 15);
      test_random_traffic(8'($urandom), 1'b1, 15);
      wait_drained();
      repeat (20) @(posedge clock);
      if (err_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
